// ===== rtl/r5pk_pkg.sv =====
// Shared types, constants and helper functions of the RGB565 to 1bpp framebuffer packer.
// No dependencies; every other file of the block imports this package.
package r5pk_pkg;

	// Panel limits and derived sizes.
	localparam int MAX_COLS    = 512;
	localparam int MAX_ROWS    = 512;
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int CCNT_W      = $clog2(MAX_COLS + 1);
	localparam int RCNT_W      = $clog2(MAX_ROWS + 1);
	localparam int BPR_MAX     = (MAX_COLS + 7) / 8;
	localparam int BPR_W       = $clog2(BPR_MAX + 1);
	localparam int FRAME_BYTES = BPR_MAX * MAX_ROWS;
	localparam int ADDR_W      = $clog2(FRAME_BYTES);

	// Field widths fixed by the interface.
	localparam int CFG_W       = 10;
	localparam int CFG_IDX_W   = 1;
	localparam int CORNER_W    = 12;
	localparam int RES_ADDR_W  = 15;
	localparam int SPAN_W      = CORNER_W + 2;
	localparam int POS_W       = CORNER_W + 2;
	localparam int SUM_W       = 8;

	localparam int             THRESHOLD  = 62;
	localparam logic [7:0]     WHITE_BYTE = 8'hFF;
	localparam logic [7:0]     MSB_MASK   = 8'h80;
	localparam logic [CFG_W-1:0] PANEL_RESET = CFG_W'(512);

	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PANEL_WIDTH  = 1'b0,
		REG_PANEL_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		REQ_BEGIN = 1'b0,
		REQ_PIXEL = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t                   req_type;
		logic signed [CORNER_W-1:0]  area_x_start;
		logic signed [CORNER_W-1:0]  area_y_start;
		logic signed [CORNER_W-1:0]  area_x_end;
		logic signed [CORNER_W-1:0]  area_y_end;
		logic [4:0]                  pixel_red;
		logic [5:0]                  pixel_green;
		logic [4:0]                  pixel_blue;
	} req_t;

	typedef struct packed {
		logic                  write_valid;
		logic [RES_ADDR_W-1:0] byte_address;
		logic [7:0]            byte_value;
		logic                  area_done;
	} res_t;

	// One classified item on its way from the front end to the back end.
	typedef struct packed {
		logic             wr;
		logic             done;
		logic             white;
		logic [COL_W-1:0] fx;
		logic [ROW_W-1:0] fy;
	} cmd_t;

	function automatic logic [CCNT_W-1:0] eff_cols(input logic [CFG_W-1:0] p);
		if (int'(p) > MAX_COLS)
			return CCNT_W'(MAX_COLS);
		return CCNT_W'(p);
	endfunction

	function automatic logic [RCNT_W-1:0] eff_rows(input logic [CFG_W-1:0] p);
		if (int'(p) > MAX_ROWS)
			return RCNT_W'(MAX_ROWS);
		return RCNT_W'(p);
	endfunction

endpackage

// ===== rtl/r5pk_front.sv =====
// Front end of the packer: accepts requests, clips areas, walks the area and
// classifies each pixel. Depends on r5pk_pkg.
module r5pk_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  r5pk_pkg::req_t               req,
	input  logic [r5pk_pkg::CCNT_W-1:0]  eff_w,
	input  logic [r5pk_pkg::RCNT_W-1:0]  eff_h,
	input  logic                         clear_busy,
	input  logic                         fifo_full,
	output logic                         push,
	output r5pk_pkg::cmd_t               cmd
);
	import r5pk_pkg::*;

	logic signed [CORNER_W-1:0] origin_x_q, origin_y_q;
	logic [CCNT_W-1:0] cw_q, col_q, col_inc;
	logic [RCNT_W-1:0] ch_q, row_q, row_inc;

	logic signed [SPAN_W-1:0] x_hi, y_hi, x_lim, y_lim, x_end, y_end, x_beg, y_beg;
	logic signed [SPAN_W-1:0] x_span, y_span;
	logic [CCNT_W-1:0] span_x;
	logic [RCNT_W-1:0] span_y;
	logic empty_area;

	logic signed [POS_W-1:0] fx, fy, fx_lim, fy_lim;
	logic on_panel, active, wrap;
	logic [SUM_W-1:0] sum;

	assign req_ready = !fifo_full && !clear_busy;
	assign push      = req_valid && req_ready;

	// Clip the new area against the panel.
	always_comb begin
		x_hi   = SPAN_W'(req.area_x_end) + SPAN_W'(1);
		y_hi   = SPAN_W'(req.area_y_end) + SPAN_W'(1);
		x_lim  = SPAN_W'(signed'({1'b0, eff_w}));
		y_lim  = SPAN_W'(signed'({1'b0, eff_h}));
		x_end  = (x_hi < x_lim) ? x_hi : x_lim;
		y_end  = (y_hi < y_lim) ? y_hi : y_lim;
		x_beg  = (req.area_x_start > 0) ? SPAN_W'(req.area_x_start) : '0;
		y_beg  = (req.area_y_start > 0) ? SPAN_W'(req.area_y_start) : '0;
		x_span = x_end - x_beg;
		y_span = y_end - y_beg;
		span_x = (x_span > 0) ? x_span[CCNT_W-1:0] : '0;
		span_y = (y_span > 0) ? y_span[RCNT_W-1:0] : '0;
		empty_area = (span_x == '0) || (span_y == '0);
	end

	// Locate and classify the current pixel.
	always_comb begin
		fx       = POS_W'(origin_x_q) + POS_W'(signed'({1'b0, col_q}));
		fy       = POS_W'(origin_y_q) + POS_W'(signed'({1'b0, row_q}));
		fx_lim   = POS_W'(signed'({1'b0, eff_w}));
		fy_lim   = POS_W'(signed'({1'b0, eff_h}));
		on_panel = (fx >= 0) && (fx < fx_lim) && (fy >= 0) && (fy < fy_lim);
		active   = (row_q < ch_q) && (col_q < cw_q);
		col_inc  = col_q + 1'b1;
		row_inc  = row_q + 1'b1;
		wrap     = (col_inc >= cw_q);
		sum      = SUM_W'(req.pixel_red) + SUM_W'(req.pixel_green) + SUM_W'(req.pixel_blue);
	end

	always_comb begin
		cmd = '0;
		if (req.req_type == REQ_BEGIN) begin
			cmd.done = empty_area;
		end else if (active) begin
			cmd.wr    = on_panel;
			cmd.white = (sum > SUM_W'(THRESHOLD));
			cmd.fx    = fx[COL_W-1:0];
			cmd.fy    = fy[ROW_W-1:0];
			cmd.done  = ((wrap ? row_inc : row_q) >= ch_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			cw_q       <= '0;
			ch_q       <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (push) begin
			if (req.req_type == REQ_BEGIN) begin
				origin_x_q <= req.area_x_start;
				origin_y_q <= req.area_y_start;
				col_q      <= '0;
				row_q      <= '0;
				cw_q       <= empty_area ? '0 : span_x;
				ch_q       <= empty_area ? '0 : span_y;
			end else if (active) begin
				if (wrap) begin
					col_q <= '0;
					row_q <= row_inc;
				end else begin
					col_q <= col_inc;
				end
			end
		end
	end

endmodule

// ===== rtl/r5pk_fifo.sv =====
// Small command queue between the front end and the back end of the packer.
// Depends on r5pk_pkg.
module r5pk_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  r5pk_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output r5pk_pkg::cmd_t pop_data,
	output logic           empty
);
	import r5pk_pkg::*;

	cmd_t                  entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== rtl/r5pk_back.sv =====
// Back end of the packer: framebuffer memory with its clearing pass and the
// read-modify-write pipeline that produces the results. Depends on r5pk_pkg.
module r5pk_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [r5pk_pkg::CCNT_W-1:0]  eff_w,
	input  logic                         fifo_empty,
	input  r5pk_pkg::cmd_t               head,
	output logic                         pop,
	output logic                         clear_busy,
	output logic                         res_valid,
	input  logic                         res_ready,
	output r5pk_pkg::res_t               res
);
	import r5pk_pkg::*;

	logic [7:0] mem [FRAME_BYTES];
	logic [7:0] rdata_q;

	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic [BPR_W-1:0]  bpr;
	logic [ADDR_W-1:0] head_addr;

	logic              vld_s1, wr_s1, done_s1, white_s1;
	logic [2:0]        bit_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic              vld_s2, wr_s2, done_s2, white_s2, byp_s2;
	logic [2:0]        bit_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [7:0]        bypd_s2;

	logic       res_vld_q;
	res_t       res_q;

	logic       out_free, s2_adv, s2_free, s1_adv, s1_free;
	logic [7:0] base, mask, new_byte;
	logic       mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [7:0] mem_wd;

	assign clear_busy = clr_busy_q;
	assign res_valid  = res_vld_q;
	assign res        = res_q;

	// Pipeline flow control.
	assign out_free = !res_vld_q || res_ready;
	assign s2_adv   = vld_s2 && out_free;
	assign s2_free  = !vld_s2 || s2_adv;
	assign s1_adv   = vld_s1 && s2_free;
	assign s1_free  = !vld_s1 || s1_adv;
	assign pop      = !fifo_empty && s1_free;

	// Byte address of the head command: row times bytes per row plus column over eight.
	always_comb begin
		bpr       = BPR_W'((CCNT_W + 1)'(eff_w) + (CCNT_W + 1)'(7) >> 3);
		head_addr = ADDR_W'(head.fy) * ADDR_W'(bpr) + ADDR_W'(head.fx >> 3);
	end

	// Merge the pixel into the byte; a write of the same byte one step ahead is forwarded.
	always_comb begin
		base     = byp_s2 ? bypd_s2 : rdata_q;
		mask     = MSB_MASK >> bit_s2;
		new_byte = white_s2 ? (base | mask) : (base & ~mask);
	end

	always_comb begin
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = WHITE_BYTE;
		end else begin
			mem_we = s2_adv && wr_s2;
			mem_wa = addr_s2;
			mem_wd = new_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (s1_adv && wr_s1)
			rdata_q <= mem[addr_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(FRAME_BYTES - 1))
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (s1_free)
				vld_s1 <= pop;
			if (s2_free)
				vld_s2 <= s1_adv;
			if (out_free)
				res_vld_q <= s2_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wr_s1    <= head.wr;
			done_s1  <= head.done;
			white_s1 <= head.white;
			bit_s1   <= head.fx[2:0];
			addr_s1  <= head_addr;
		end
		if (s1_adv) begin
			wr_s2    <= wr_s1;
			done_s2  <= done_s1;
			white_s2 <= white_s1;
			bit_s2   <= bit_s1;
			addr_s2  <= addr_s1;
			byp_s2   <= s2_adv && wr_s2 && (addr_s2 == addr_s1);
			bypd_s2  <= new_byte;
		end
		if (s2_adv) begin
			res_q.write_valid  <= wr_s2;
			res_q.byte_address <= wr_s2 ? RES_ADDR_W'(addr_s2) : '0;
			res_q.byte_value   <= wr_s2 ? new_byte : '0;
			res_q.area_done    <= done_s2;
		end
	end

endmodule

// ===== rtl/rgb565_to_1bpp_framebuffer_packer.sv =====
// Top level of the RGB565 to 1bpp framebuffer packer: panel registers and the
// front end, command queue and back end. Depends on r5pk_pkg and all r5pk_ modules.
//
// Usage: the request channel (req_valid, req_ready, req) carries either a begin
// item with the inclusive corners of an area or one RGB565 pixel. A begin item
// clips the area to the panel; the pixels that follow fill it in row order. A
// pixel whose red+green+blue exceeds 62 is white (bit set), else black. Every
// request transfer yields exactly one result transfer on (res_valid, res_ready,
// res): the framebuffer byte that was updated and its address, or a result with
// write_valid low for begin items, off-panel pixels and pixels past the area.
// area_done marks the last pixel of an area and a begin item whose area is empty.
// A request passes the queue, s1, s2 and the output register before res_valid;
// one item is taken every cycle while the receiver keeps up, as each pixel costs
// one read and one write of the framebuffer memory through its two ports, with
// forwarding between neighbors. After reset the framebuffer is swept to white,
// one byte per cycle, over all FRAME_BYTES (32768) bytes; req_ready stays low
// until the sweep is over, while the panel registers can be written at any time.
// When the receiver stalls the output register holds its result, the pipeline
// fills and a four-entry queue absorbs further requests before req_ready drops.
module rgb565_to_1bpp_framebuffer_packer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [r5pk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [r5pk_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  r5pk_pkg::req_t                  req,
	output logic                            res_valid,
	input  logic                            res_ready,
	output r5pk_pkg::res_t                  res
);
	import r5pk_pkg::*;

	logic [CFG_W-1:0]  panel_width_q, panel_height_q;
	logic [CCNT_W-1:0] eff_w;
	logic [RCNT_W-1:0] eff_h;

	logic clear_busy, fifo_full, fifo_empty, push, pop;
	cmd_t push_cmd, head_cmd;

	// Panel registers; values above the panel limits are taken as the limits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q  <= PANEL_RESET;
			panel_height_q <= PANEL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PANEL_WIDTH:  panel_width_q  <= cfg_wdata;
				REG_PANEL_HEIGHT: panel_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign eff_w = eff_cols(panel_width_q);
	assign eff_h = eff_rows(panel_height_q);

	// The front end classifies each transfer and queues one command for it.
	r5pk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.eff_w      (eff_w),
		.eff_h      (eff_h),
		.clear_busy (clear_busy),
		.fifo_full  (fifo_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	r5pk_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (fifo_full),
		.pop       (pop),
		.pop_data  (head_cmd),
		.empty     (fifo_empty)
	);

	// The back end performs the framebuffer update and drives the result channel.
	r5pk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.eff_w      (eff_w),
		.fifo_empty (fifo_empty),
		.head       (head_cmd),
		.pop        (pop),
		.clear_busy (clear_busy),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule
